// ===== rtl/tmcal_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcal_pkg
// Shared types and constants of the trimmed-mean two-point calibration block.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcal_pkg;

   localparam int UNIT_WIDTH  = 64;
   localparam int STEP_WIDTH  = 7;
   localparam int OUT_WIDTH   = 24;
   localparam int CFG_WIDTH   = 24;
   localparam int VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH = 3;
   localparam int COUNT_CFG_WIDTH = 4;

   // register indexes
   localparam logic [INDEX_WIDTH-1:0] CSR_SAMPLES     = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] CSR_PHYS_FIRST  = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] CSR_PHYS_SECOND = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] CSR_RAW_FIRST   = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] CSR_RAW_SECOND  = 3'd4;

   // register reset values and the floor on the sample count
   localparam logic [COUNT_CFG_WIDTH-1:0] SAMPLES_RESET = 4'd5;
   localparam logic signed [CFG_WIDTH-1:0] PHYS_FIRST_RESET  = 24'sd0;
   localparam logic signed [CFG_WIDTH-1:0] PHYS_SECOND_RESET = 24'sd256;
   localparam logic signed [CFG_WIDTH-1:0] RAW_FIRST_RESET   = 24'sd0;
   localparam logic signed [CFG_WIDTH-1:0] RAW_SECOND_RESET  = 24'sd256;
   localparam logic [COUNT_CFG_WIDTH-1:0] SAMPLES_FLOOR = 4'd3;

   // saturation limits on the quotient magnitude
   localparam logic [UNIT_WIDTH-1:0] MAG_NEG_LIMIT = 64'h0000_0000_8000_0000;
   localparam logic [UNIT_WIDTH-1:0] MAG_POS_LIMIT = 64'h0000_0000_7fff_ffff;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;

   // shared unit operations
   localparam logic MDU_OP_MUL = 1'b0;
   localparam logic MDU_OP_DIV = 1'b1;

   typedef struct packed {
      logic                  start;
      logic                  op;
      logic [STEP_WIDTH-1:0] steps;
      logic [UNIT_WIDTH-1:0] shift_operand;
      logic [UNIT_WIDTH-1:0] fixed_operand;
   } mdu_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/tmcal_ifs.sv =====
// ----------------------------------------------------------------------------
// tmcal channel interfaces
// Reading, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmcal_req_if #(parameter int READING_WIDTH = 24) ();
   logic                            valid;
   logic                            ready;
   logic signed [READING_WIDTH-1:0] reading;
   modport source (output valid, output reading, input ready);
   modport sink (input valid, input reading, output ready);
endinterface

interface tmcal_rsp_if import tmcal_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [OUT_WIDTH-1:0]   min_reading;
   logic signed [OUT_WIDTH-1:0]   max_reading;
   logic signed [OUT_WIDTH-1:0]   trimmed_mean;
   logic signed [VALUE_WIDTH-1:0] value_tenths;
   logic                          span_error;
   modport source (output valid, output min_reading, output max_reading,
                   output trimmed_mean, output value_tenths, output span_error,
                   input ready);
   modport sink (input valid, input min_reading, input max_reading,
                 input trimmed_mean, input value_tenths, input span_error,
                 output ready);
endinterface

interface tmcal_csr_if import tmcal_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/trimmed_mean_two_point_calibration.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_two_point_calibration
// Running min/max/sum over a measurement, trimmed mean, two-point linear
// calibration to tenths with rounding and saturation.
//
//   channel   dir   payload                                           handshake
//   req_bus   in    reading                                           valid/ready
//   rsp_bus   out   min_reading, max_reading, trimmed_mean,           valid/ready
//                   value_tenths, span_error
//   csr_bus   in    index, data                                       valid/ready
//
// A reading that does not close a measurement only updates min/max/sum/count,
// and the block stays ready. The closing reading runs the trim and mean divide,
// then, unless the calibration span is zero, two multiplies, scaling, rounding
// and the final divide, on the shared one-bit-per-cycle multiply/divide unit.
// Reset is synchronous and loads the register defaults; no clearing pass.
// A finished result waits in the output register while readings keep flowing;
// only the next closing reading waits for it to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module trimmed_mean_two_point_calibration
   import tmcal_pkg::*;
#(
   parameter int MAX_READINGS  = 15,
   parameter int READING_WIDTH = 24
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   tmcal_req_if.sink   req_bus,
   tmcal_rsp_if.source rsp_bus,
   tmcal_csr_if.sink   csr_bus
);

   localparam int RW  = READING_WIDTH;
   localparam int CW  = $clog2(MAX_READINGS + 1);
   localparam int SW  = RW + 4;
   localparam int DW  = RW + 5;
   localparam int BW  = ((RW > CFG_WIDTH) ? RW : CFG_WIDTH) + 1;
   localparam int PDW = CFG_WIDTH + 1;
   localparam int UW  = UNIT_WIDTH;
   localparam logic [COUNT_CFG_WIDTH-1:0] MAX_CODE = COUNT_CFG_WIDTH'(MAX_READINGS);
   localparam logic signed [RW-1:0] MOST_POS = {1'b0, {(RW-1){1'b1}}};
   localparam logic signed [RW-1:0] MOST_NEG = {1'b1, {(RW-1){1'b0}}};

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_TRIM      = 4'd1;
   localparam logic [3:0] ST_MDIV_GO   = 4'd2;
   localparam logic [3:0] ST_MDIV_WAIT = 4'd3;
   localparam logic [3:0] ST_BDIFF     = 4'd4;
   localparam logic [3:0] ST_MUL1_GO   = 4'd5;
   localparam logic [3:0] ST_MUL1_WAIT = 4'd6;
   localparam logic [3:0] ST_MUL2_GO   = 4'd7;
   localparam logic [3:0] ST_MUL2_WAIT = 4'd8;
   localparam logic [3:0] ST_SCALE     = 4'd9;
   localparam logic [3:0] ST_ABS       = 4'd10;
   localparam logic [3:0] ST_BIAS      = 4'd11;
   localparam logic [3:0] ST_FDIV_GO   = 4'd12;
   localparam logic [3:0] ST_FDIV_WAIT = 4'd13;
   localparam logic [3:0] ST_PUBLISH   = 4'd14;

   // configuration
   logic [COUNT_CFG_WIDTH-1:0]  samples_ff;
   logic signed [CFG_WIDTH-1:0] phys0_ff, phys1_ff, raw0_ff, raw1_ff;

   // accumulators
   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [RW-1:0] min_ff, min_in;
   logic signed [RW-1:0] max_ff, max_in;

   // working registers
   logic signed [DW-1:0]  diff_ff, diff_in;
   logic signed [PDW-1:0] span_ff, span_in;
   logic [PDW-1:0]        spanmag_ff, spanmag_in;
   logic signed [PDW-1:0] pdiff_ff, pdiff_in;
   logic                  err_ff, err_in;
   logic signed [RW-1:0]  mean_ff, mean_in;
   logic signed [BW-1:0]  bdiff_ff, bdiff_in;
   logic                  pneg_ff, pneg_in;
   logic signed [UW-1:0]  prod_ff, prod_in;
   logic [UW-1:0]         mag_ff, mag_in;
   logic                  qneg_ff, qneg_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_WIDTH-1:0]   out_min_ff, out_max_ff, out_mean_ff;
   logic signed [VALUE_WIDTH-1:0] out_value_ff, value_ff, value_in;
   logic                          out_err_ff;
   logic                          load_out;

   // combinational helpers
   logic signed [RW-1:0]       reading;
   logic                       req_xfer;
   logic [CW-1:0]              count_next;
   logic [COUNT_CFG_WIDTH-1:0] eff_count;
   logic                       closing;
   logic [DW-1:0]              diff_mag;
   logic [BW-1:0]              bdiff_mag;
   logic [PDW-1:0]             pdiff_mag;
   logic [PDW-1:0]             phys0_mag;
   logic signed [PDW-1:0]      phys0_ext;
   logic signed [RW-1:0]       quot_rw;

   mdu_cmd_type       mdu_cmd;
   logic              mdu_done;
   logic [UW-1:0]     mdu_result;

   tmcal_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mdu_cmd),
      .done   (mdu_done),
      .result (mdu_result)
   );

   assign reading       = req_bus.reading;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      priority if (samples_ff < SAMPLES_FLOOR) begin
         eff_count = SAMPLES_FLOOR;
      end else if (samples_ff > MAX_CODE) begin
         eff_count = MAX_CODE;
      end else begin
         eff_count = samples_ff;
      end
      count_next = count_ff + CW'(1);
      closing    = (COUNT_CFG_WIDTH'(count_next) >= eff_count);
      diff_mag   = diff_ff[DW-1] ? -diff_ff : diff_ff;
      bdiff_mag  = bdiff_ff[BW-1] ? -bdiff_ff : bdiff_ff;
      pdiff_mag  = pdiff_ff[PDW-1] ? -pdiff_ff : pdiff_ff;
      phys0_ext  = PDW'(phys0_ff);
      phys0_mag  = phys0_ext[PDW-1] ? -phys0_ext : phys0_ext;
      quot_rw    = mdu_result[RW-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      diff_in    = diff_ff;
      span_in    = span_ff;
      spanmag_in = spanmag_ff;
      pdiff_in   = pdiff_ff;
      err_in     = err_ff;
      mean_in    = mean_ff;
      bdiff_in   = bdiff_ff;
      pneg_in    = pneg_ff;
      prod_in    = prod_ff;
      mag_in     = mag_ff;
      qneg_in    = qneg_ff;
      value_in   = value_ff;
      load_out   = 1'b0;
      mdu_cmd    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               max_in   = (reading > max_ff) ? reading : max_ff;
               min_in   = (reading < min_ff) ? reading : min_ff;
               sum_in   = sum_ff + SW'(reading);
               count_in = count_next;
               if (closing) begin
                  state_in = ST_TRIM;
               end
            end
         end
         ST_TRIM: begin
            diff_in  = DW'(sum_ff) - DW'(min_ff) - DW'(max_ff);
            span_in  = PDW'(raw1_ff) - PDW'(raw0_ff);
            pdiff_in = PDW'(phys1_ff) - PDW'(phys0_ff);
            err_in   = (raw1_ff == raw0_ff);
            state_in = ST_MDIV_GO;
         end
         ST_MDIV_GO: begin
            mdu_cmd.start         = 1'b1;
            mdu_cmd.op            = MDU_OP_DIV;
            mdu_cmd.steps         = STEP_WIDTH'(DW);
            mdu_cmd.shift_operand = UW'(diff_mag) << (UW - DW);
            mdu_cmd.fixed_operand = UW'(count_ff) - UW'(2);
            spanmag_in            = span_ff[PDW-1] ? -span_ff : span_ff;
            state_in              = ST_MDIV_WAIT;
         end
         ST_MDIV_WAIT: begin
            if (mdu_done) begin
               mean_in = diff_ff[DW-1] ? -quot_rw : quot_rw;
               if (err_ff) begin
                  value_in = '0;
                  state_in = ST_PUBLISH;
               end else begin
                  state_in = ST_BDIFF;
               end
            end
         end
         ST_BDIFF: begin
            bdiff_in = BW'(mean_ff) - BW'(raw0_ff);
            state_in = ST_MUL1_GO;
         end
         ST_MUL1_GO: begin
            mdu_cmd.start         = 1'b1;
            mdu_cmd.op            = MDU_OP_MUL;
            mdu_cmd.steps         = STEP_WIDTH'(BW);
            mdu_cmd.shift_operand = UW'(bdiff_mag);
            mdu_cmd.fixed_operand = UW'(pdiff_mag);
            pneg_in               = bdiff_ff[BW-1] ^ pdiff_ff[PDW-1];
            state_in              = ST_MUL1_WAIT;
         end
         ST_MUL1_WAIT: begin
            if (mdu_done) begin
               prod_in  = pneg_ff ? -mdu_result : mdu_result;
               state_in = ST_MUL2_GO;
            end
         end
         ST_MUL2_GO: begin
            mdu_cmd.start         = 1'b1;
            mdu_cmd.op            = MDU_OP_MUL;
            mdu_cmd.steps         = STEP_WIDTH'(PDW);
            mdu_cmd.shift_operand = UW'(spanmag_ff);
            mdu_cmd.fixed_operand = UW'(phys0_mag);
            pneg_in               = phys0_ext[PDW-1] ^ span_ff[PDW-1];
            state_in              = ST_MUL2_WAIT;
         end
         ST_MUL2_WAIT: begin
            if (mdu_done) begin
               prod_in  = pneg_ff ? prod_ff - mdu_result : prod_ff + mdu_result;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = (prod_ff <<< 3) + (prod_ff <<< 1);
            state_in = ST_ABS;
         end
         ST_ABS: begin
            mag_in   = prod_ff[UW-1] ? -prod_ff : prod_ff;
            qneg_in  = prod_ff[UW-1] ^ span_ff[PDW-1];
            state_in = ST_BIAS;
         end
         ST_BIAS: begin
            mag_in   = mag_ff + (UW'(spanmag_ff) << 7);
            state_in = ST_FDIV_GO;
         end
         ST_FDIV_GO: begin
            mdu_cmd.start         = 1'b1;
            mdu_cmd.op            = MDU_OP_DIV;
            mdu_cmd.steps         = STEP_WIDTH'(UW);
            mdu_cmd.shift_operand = mag_ff;
            mdu_cmd.fixed_operand = UW'(spanmag_ff) << 8;
            state_in              = ST_FDIV_WAIT;
         end
         ST_FDIV_WAIT: begin
            if (mdu_done) begin
               if (qneg_ff) begin
                  value_in = (mdu_result > MAG_NEG_LIMIT) ? VALUE_MIN
                                                          : -mdu_result[VALUE_WIDTH-1:0];
               end else begin
                  value_in = (mdu_result > MAG_POS_LIMIT) ? VALUE_MAX
                                                          : mdu_result[VALUE_WIDTH-1:0];
               end
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_out = 1'b1;
               count_in = '0;
               sum_in   = '0;
               min_in   = MOST_POS;
               max_in   = MOST_NEG;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_bus.ready);
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         samples_ff <= SAMPLES_RESET;
         phys0_ff   <= PHYS_FIRST_RESET;
         phys1_ff   <= PHYS_SECOND_RESET;
         raw0_ff    <= RAW_FIRST_RESET;
         raw1_ff    <= RAW_SECOND_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_SAMPLES:     samples_ff <= csr_bus.data[COUNT_CFG_WIDTH-1:0];
            CSR_PHYS_FIRST:  phys0_ff   <= csr_bus.data;
            CSR_PHYS_SECOND: phys1_ff   <= csr_bus.data;
            CSR_RAW_FIRST:   raw0_ff    <= csr_bus.data;
            CSR_RAW_SECOND:  raw1_ff    <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= MOST_POS;
         max_ff       <= MOST_NEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_ff    <= diff_in;
      span_ff    <= span_in;
      spanmag_ff <= spanmag_in;
      pdiff_ff   <= pdiff_in;
      err_ff     <= err_in;
      mean_ff    <= mean_in;
      bdiff_ff   <= bdiff_in;
      pneg_ff    <= pneg_in;
      prod_ff    <= prod_in;
      mag_ff     <= mag_in;
      qneg_ff    <= qneg_in;
      value_ff   <= value_in;
   end

   // result transfer register
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_min_ff   <= OUT_WIDTH'(min_ff);
         out_max_ff   <= OUT_WIDTH'(max_ff);
         out_mean_ff  <= OUT_WIDTH'(mean_ff);
         out_value_ff <= value_ff;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.min_reading  = out_min_ff;
   assign rsp_bus.max_reading  = out_max_ff;
   assign rsp_bus.trimmed_mean = out_mean_ff;
   assign rsp_bus.value_tenths = out_value_ff;
   assign rsp_bus.span_error   = out_err_ff;

endmodule

`default_nettype wire

// ===== rtl/tmcal_mdu.sv =====
// ----------------------------------------------------------------------------
// tmcal_mdu
// Shared iterative unit: unsigned shift-add multiply and restoring divide,
// one bit per cycle through a single adder.
// ----------------------------------------------------------------------------
`default_nettype none

module tmcal_mdu
   import tmcal_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mdu_cmd_type       cmd,
   output logic                   done,
   output logic [UNIT_WIDTH-1:0]  result
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  op_ff, op_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [UNIT_WIDTH:0]   acc_ff, acc_in;
   logic [UNIT_WIDTH-1:0] fix_ff, fix_in;
   logic [UNIT_WIDTH-1:0] shr_ff, shr_in;

   logic [UNIT_WIDTH:0]   rem_shift;
   logic [UNIT_WIDTH:0]   add_x;
   logic [UNIT_WIDTH:0]   add_y;
   logic                  add_sub;
   logic [UNIT_WIDTH+1:0] add_sum;
   logic                  no_borrow;

   // the one adder
   always_comb begin
      rem_shift = {acc_ff[UNIT_WIDTH-1:0], shr_ff[UNIT_WIDTH-1]};
      if (op_ff == MDU_OP_DIV) begin
         add_x   = rem_shift;
         add_y   = ~{1'b0, fix_ff};
         add_sub = 1'b1;
      end else begin
         add_x   = acc_ff;
         add_y   = shr_ff[0] ? {1'b0, fix_ff} : '0;
         add_sub = 1'b0;
      end
      add_sum   = {1'b0, add_x} + {1'b0, add_y} + {{(UNIT_WIDTH+1){1'b0}}, add_sub};
      no_borrow = add_sum[UNIT_WIDTH+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      step_in = step_ff;
      acc_in  = acc_ff;
      fix_in  = fix_ff;
      shr_in  = shr_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         step_in = cmd.steps;
         acc_in  = '0;
         fix_in  = cmd.fixed_operand;
         shr_in  = cmd.shift_operand;
      end else if (busy_ff) begin
         if (op_ff == MDU_OP_DIV) begin
            acc_in = no_borrow ? add_sum[UNIT_WIDTH:0] : rem_shift;
            shr_in = {shr_ff[UNIT_WIDTH-2:0], no_borrow};
         end else begin
            acc_in = add_sum[UNIT_WIDTH:0];
            fix_in = {fix_ff[UNIT_WIDTH-2:0], 1'b0};
            shr_in = {1'b0, shr_ff[UNIT_WIDTH-1:1]};
         end
         step_in = step_ff - STEP_WIDTH'(1);
         if (step_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      fix_ff  <= fix_in;
      shr_ff  <= shr_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == MDU_OP_DIV) ? shr_ff : acc_ff[UNIT_WIDTH-1:0];

endmodule

`default_nettype wire
